// ===== rtl/sbb_pkg.sv =====
// Shared types and constants for the separable box blur.
// Used by sbb_ctrl, sbb_dp and separable_box_blur; no dependencies.
package sbb_pkg;

  // Default sizing of the top level
  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int KS_W      = 4;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [KS_W-1:0] RST_WIN_SIDE     = 4'd3;
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // Item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam int MIN_KERNEL = 3;
  localparam int PIX_MAX    = 255;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr;
    logic shift;
    logic c_init;
    logic c_inc;
    logic rm_setup;
    logic acc;
    logic div_go;
    logic rm_write;
    logic adv_take;
    logic cm_setup;
    logic cm_read;
    logic cm_acc;
    logic out_load;
  } sbb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode;
    logic need_clear;
    logic taken_done;
    logic give_pending;
    logic emit_ok;
    logic x_row_mean;
    logic acc_last;
    logic col_last;
    logic div_done;
    logic out_busy;
  } sbb_stat_t;

endpackage

// ===== rtl/sbb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the rounded means.
// Depends on nothing but its parameters.
module sbb_div #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps_left;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  dividend;
  logic [DEN_W-1:0]  divisor;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Partial remainder with the next dividend bit shifted in
  assign trial = {rem, dividend[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign quot  = dividend;

  // Iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else if (start) begin
      busy       <= 1'b1;
      done       <= 1'b0;
      steps_left <= STEP_W'(NUM_W);
      dividend   <= num;
      divisor    <= den;
      rem        <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      dividend   <= {dividend[NUM_W-2:0], fits};
      steps_left <= steps_left - STEP_W'(1);
      if (steps_left == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sbb_ctrl.sv =====
// Sequencer of the separable box blur: steps one item through the datapath.
// Depends on sbb_pkg for the command and status structs.
module sbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbb_pkg::sbb_stat_t st,
  output sbb_pkg::sbb_cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE, PREP, CHK, DEC, RM_TEST, RM_SETUP, RM_ACC, RM_DIVGO, RM_DIVW,
    TAKE, EMIT_CHK, CM_SETUP, CM_RD, CM_ACC, CM_DIVGO, CM_DIVW, OUT
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = PREP;
        end
      end
      // derived frame values settle
      PREP: state_next = CHK;
      CHK: begin
        cmd.clr    = st.need_clear;
        state_next = DEC;
      end
      DEC: begin
        if (st.mode == sbb_pkg::MODE_PIXEL) begin
          if (st.taken_done) begin
            state_next = IDLE;
          end else begin
            cmd.shift  = 1'b1;
            state_next = RM_TEST;
          end
        end else if (st.taken_done && st.give_pending) begin
          state_next = CM_SETUP;
        end else begin
          state_next = IDLE;
        end
      end
      RM_TEST: begin
        if (st.x_row_mean) begin
          cmd.c_init = 1'b1;
          state_next = RM_SETUP;
        end else begin
          state_next = TAKE;
        end
      end
      RM_SETUP: begin
        cmd.rm_setup = 1'b1;
        state_next   = RM_ACC;
      end
      RM_ACC: begin
        cmd.acc = 1'b1;
        if (st.acc_last) state_next = RM_DIVGO;
      end
      RM_DIVGO: begin
        cmd.div_go = 1'b1;
        state_next = RM_DIVW;
      end
      RM_DIVW: begin
        if (st.div_done) begin
          cmd.rm_write = 1'b1;
          if (st.col_last) begin
            state_next = TAKE;
          end else begin
            cmd.c_inc  = 1'b1;
            state_next = RM_SETUP;
          end
        end
      end
      TAKE: begin
        cmd.adv_take = 1'b1;
        state_next   = EMIT_CHK;
      end
      EMIT_CHK: state_next = st.emit_ok ? CM_SETUP : IDLE;
      CM_SETUP: begin
        cmd.cm_setup = 1'b1;
        state_next   = CM_RD;
      end
      CM_RD: begin
        cmd.cm_read = 1'b1;
        state_next  = CM_ACC;
      end
      CM_ACC: begin
        cmd.cm_acc = 1'b1;
        state_next = st.acc_last ? CM_DIVGO : CM_RD;
      end
      CM_DIVGO: begin
        cmd.div_go = 1'b1;
        state_next = CM_DIVW;
      end
      CM_DIVW: begin
        if (st.div_done) state_next = OUT;
      end
      OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
    end
  end

endmodule

// ===== rtl/sbb_dp.sv =====
// Datapath of the separable box blur: registers, counters, raw window,
// row-mean ring memory, accumulator and output register. Depends on sbb_pkg, sbb_div.
module sbb_dp #(
  parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_mode,
  input  logic [sbb_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sbb_pkg::PIX_W-1:0]      out_pixel,
  output logic                           out_last,
  input  sbb_pkg::sbb_cmd_t               cmd,
  output sbb_pkg::sbb_stat_t              st
);

  localparam int PIX_W     = sbb_pkg::PIX_W;
  localparam int RAW_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int RING_ROWS = 3 * MAX_RADIUS + 1;
  localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int TAP_W     = $clog2(RAW_DEPTH);
  localparam int CNT_W     = $clog2(RAW_DEPTH + 1);
  localparam int SUM_W     = $clog2(RAW_DEPTH * sbb_pkg::PIX_MAX + 1);
  localparam int NUM_W     = SUM_W + 2;
  localparam int DEN_W     = CNT_W + 1;
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int TW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LW        = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int RGW       = $clog2(RING_ROWS);
  localparam int AW        = $clog2(MEM_DEPTH);

  // Configuration registers
  logic [sbb_pkg::KS_W-1:0] win_side;
  logic [sbb_pkg::FW_W-1:0] frame_width;
  logic [sbb_pkg::FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_side     <= sbb_pkg::RST_WIN_SIDE;
      frame_width  <= sbb_pkg::RST_FRAME_WIDTH;
      frame_height <= sbb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbb_pkg::REG_WIN_SIDE:     win_side     <= cfg_data[sbb_pkg::KS_W-1:0];
        sbb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sbb_pkg::FW_W-1:0];
        sbb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[sbb_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective radius, width and height
  logic [sbb_pkg::KS_W-1:0] k_eff;
  logic [sbb_pkg::KS_W-1:0] r_raw;
  logic [R_W-1:0]           r_eff;
  logic [WW-1:0]            w_eff;
  logic [HW-1:0]            h_eff;
  logic [TW-1:0]            total, total_c;
  logic [LW-1:0]            lag, lag_c;

  assign k_eff = (int'(win_side) < sbb_pkg::MIN_KERNEL || !win_side[0]) ?
                 sbb_pkg::KS_W'(sbb_pkg::MIN_KERNEL) : win_side;
  assign r_raw = k_eff >> 1;
  assign r_eff = (int'(r_raw) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(r_raw);
  assign w_eff = (frame_width == '0) ? WW'(1) :
                 (int'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign h_eff = (frame_height == '0) ? HW'(1) :
                 (int'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
  assign total_c = TW'(w_eff) * TW'(h_eff);
  assign lag_c   = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);

  always_ff @(posedge clk) begin
    total <= total_c;
    lag   <= lag_c;
  end

  // Item latch
  logic             mode_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_mode;
      pix_q  <= in_pixel;
    end
  end

  // Raw window: tap k holds the pixel k columns left of the current one
  logic [PIX_W-1:0] taps [RAW_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      taps[0] <= pix_q;
      for (int i = 1; i < RAW_DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  // Frame position counters
  logic [TW-1:0]  taken, given;
  logic [XW-1:0]  tx, gx;
  logic [YW-1:0]  ty, gy;
  logic [RGW-1:0] ty_ring, gy_ring;
  logic           x_last, x_ge_r, g_x_last, frame_end_c;

  assign x_last      = WW'(tx) == w_eff - WW'(1);
  assign x_ge_r      = WW'(tx) >= WW'(r_eff);
  assign g_x_last    = WW'(gx) == w_eff - WW'(1);
  assign frame_end_c = given + TW'(1) == total;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr || (cmd.out_load && frame_end_c)) begin
      taken   <= '0;
      given   <= '0;
      tx      <= '0;
      ty      <= '0;
      ty_ring <= '0;
      gx      <= '0;
      gy      <= '0;
      gy_ring <= '0;
    end else begin
      if (cmd.adv_take) begin
        taken <= taken + TW'(1);
        if (x_last) begin
          tx      <= '0;
          ty      <= ty + YW'(1);
          ty_ring <= (int'(ty_ring) == RING_ROWS - 1) ? '0 : ty_ring + RGW'(1);
        end else begin
          tx <= tx + XW'(1);
        end
      end
      if (cmd.out_load) begin
        given <= given + TW'(1);
        if (g_x_last) begin
          gx      <= '0;
          gy      <= gy + YW'(1);
          gy_ring <= (int'(gy_ring) == RING_ROWS - 1) ? '0 : gy_ring + RGW'(1);
        end else begin
          gx <= gx + XW'(1);
        end
      end
    end
  end

  // Row-mean column and its span over the raw window
  logic [XW-1:0]  col;
  logic [WW:0]    colw, rw, txw, lo_c, hi_c;
  logic [YW:0]    gyw, ryw, hyw, rest, d_lo, d_hi;
  logic [RGW:0]   gr, dl;

  assign colw = (WW+1)'(col);
  assign rw   = (WW+1)'(r_eff);
  assign txw  = (WW+1)'(tx);
  assign lo_c = (colw >= rw) ? colw - rw : '0;
  assign hi_c = (colw + rw < (WW+1)'(w_eff)) ? colw + rw : (WW+1)'(w_eff) - (WW+1)'(1);

  // Column-mean row span and first ring row
  assign gyw  = (YW+1)'(gy);
  assign ryw  = (YW+1)'(r_eff);
  assign hyw  = (YW+1)'(h_eff);
  assign rest = hyw - (YW+1)'(1) - gyw;
  assign d_lo = (gyw >= ryw) ? ryw : gyw;
  assign d_hi = (rest >= ryw) ? ryw : rest;
  assign gr   = (RGW+1)'(gy_ring);
  assign dl   = (RGW+1)'(d_lo);

  always_ff @(posedge clk) begin
    if (cmd.c_init) col <= x_ge_r ? tx - XW'(r_eff) : '0;
    else if (cmd.c_inc) col <= col + XW'(1);
  end

  // Accumulator over taps or ring rows
  logic [TAP_W-1:0] tap_k;
  logic [CNT_W-1:0] n_left;
  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_cnt;
  logic [RGW-1:0]   cm_ring;
  logic [PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.rm_setup) begin
      tap_k   <= TAP_W'(txw - lo_c);
      n_left  <= CNT_W'(hi_c - lo_c + (WW+1)'(1));
      acc_sum <= '0;
      acc_cnt <= '0;
    end else if (cmd.acc) begin
      acc_sum <= acc_sum + SUM_W'(taps[tap_k]);
      acc_cnt <= acc_cnt + CNT_W'(1);
      tap_k   <= tap_k - TAP_W'(1);
      n_left  <= n_left - CNT_W'(1);
    end else if (cmd.cm_setup) begin
      n_left  <= CNT_W'(d_lo + d_hi + (YW+1)'(1));
      cm_ring <= (gr >= dl) ? RGW'(gr - dl) : RGW'(gr + (RGW+1)'(RING_ROWS) - dl);
      acc_sum <= '0;
      acc_cnt <= '0;
    end else if (cmd.cm_acc) begin
      acc_sum <= acc_sum + SUM_W'(rd_data);
      acc_cnt <= acc_cnt + CNT_W'(1);
      n_left  <= n_left - CNT_W'(1);
      cm_ring <= (int'(cm_ring) == RING_ROWS - 1) ? '0 : cm_ring + RGW'(1);
    end
  end

  // Rounded mean: (2*sum + count) / (2*count), saturated to a pixel
  logic [NUM_W-1:0] num_c, quot;
  logic [DEN_W-1:0] den_c;
  logic             div_done;
  logic [PIX_W-1:0] mean;

  assign num_c = (NUM_W'(acc_sum) << 1) + NUM_W'(acc_cnt);
  assign den_c = DEN_W'(acc_cnt) << 1;
  assign mean  = (quot > NUM_W'(sbb_pkg::PIX_MAX)) ? PIX_W'(sbb_pkg::PIX_MAX) :
                 quot[PIX_W-1:0];

  sbb_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_go),
    .num  (num_c),
    .den  (den_c),
    .done (div_done),
    .quot (quot)
  );

  // Row-mean ring memory
  logic [PIX_W-1:0] row_mem [MEM_DEPTH];
  logic [AW-1:0]    wr_addr, rd_addr;

  assign wr_addr = AW'(ty_ring) * AW'(MAX_WIDTH) + AW'(col);
  assign rd_addr = AW'(cm_ring) * AW'(MAX_WIDTH) + AW'(gx);

  always_ff @(posedge clk) begin
    if (cmd.rm_write) row_mem[wr_addr] <= mean;
    if (cmd.cm_read) rd_data <= row_mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel <= mean;
      out_last  <= frame_end_c;
    end
  end

  // Status
  assign st.mode         = mode_q;
  assign st.need_clear   = given >= total;
  assign st.taken_done   = taken >= total;
  assign st.give_pending = given < total;
  assign st.emit_ok      = (TW+1)'(given) + (TW+1)'(lag) < (TW+1)'(taken);
  assign st.x_row_mean   = x_last || x_ge_r;
  assign st.acc_last     = n_left == CNT_W'(1);
  assign st.col_last     = !x_last || (col == tx);
  assign st.div_done     = div_done;
  assign st.out_busy     = out_valid && !out_ready;

  // Checks
  a_given_le_taken: assert property (@(posedge clk) disable iff (rst) given <= taken)
    else $error("more results given than pixels taken");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten while stalled");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> acc_cnt != '0)
    else $error("mean started with an empty window");
  a_div_done_rose: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |=> !div_done)
    else $error("divider done not cleared by start");

endmodule

// ===== rtl/separable_box_blur.sv =====
// Top level of the separable box blur: sequencer plus datapath.
// Depends on sbb_pkg, sbb_ctrl, sbb_dp (and sbb_div below it).
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: pixel_in, tuser: mode
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: pixel_out, tlast: frame_end
//  cfg      | in        | cfg_we (no wait)             | cfg_index, cfg_data
//
// One item at a time. A pixel computes each of its N row means in turn
// (N = 0, 1, or up to r+1 at a row end; n <= 2r+1 accumulate steps, then a 14-bit
// bit-serial divide waited on). A drain tick or ignored pixel computes no row mean.
// An item that gives a result then computes the column mean and waits out any output stall
// (c <= 2r+1 rows read from the single-port ring memory, a read and an accumulate step a row).
// Reset (rst, synchronous) clears counters, config and out_valid; ring memory needs no clearing.
// A waiting result sits in the output register; the next item is taken meanwhile and
// stalls only when it has its own result ready while m_axis_tready is low.
module separable_box_blur #(
  parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sbb_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic                          s_axis_tuser,   // [0] mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sbb_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
  output logic                          m_axis_tlast    // frame_end
);

  sbb_pkg::sbb_cmd_t  cmd;
  sbb_pkg::sbb_stat_t st;

  sbb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  sbb_dp #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_mode  (s_axis_tuser),
    .in_pixel (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_pixel(m_axis_tdata),
    .out_last (m_axis_tlast),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
